>>> src/pswc_pkg.sv
// shared types and constants for the permutation swap and range count block
`default_nettype none

package pswc_pkg;

	localparam int VAL_W = 10;
	localparam int FLD_W = 11;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SWAP  = 2'd1;
	localparam logic [1:0] OP_COUNT = 2'd2;

	localparam logic [FLD_W-1:0] COUNT_MAX = 11'h7ff;

	typedef logic [VAL_W-1:0] val_t;

	// ring control driven by the sequencer into the cell row
	typedef struct packed {
		logic shift;
		val_t fb;
	} ring_ctl_t;

endpackage

`default_nettype wire

>>> src/pswc_cell.sv
// one storage cell of the rotating entry ring
`default_nettype none

module pswc_cell (
	input  wire logic           clk,
	input  wire logic           shift,
	input  wire pswc_pkg::val_t nxt,
	output pswc_pkg::val_t      value
);

	pswc_pkg::val_t value_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= nxt;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

>>> src/pswc_ctrl.sv
// lap sequencer: walks the ring head, applies load and swap, counts matches
`default_nettype none

module pswc_ctrl #(
	parameter int ENTRIES = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic [1:0]                     operation,
	input  wire logic [pswc_pkg::FLD_W-1:0]     first_index,
	input  wire logic [pswc_pkg::FLD_W-1:0]     second_index,
	input  wire pswc_pkg::val_t                 load_value,
	input  wire logic [pswc_pkg::FLD_W-1:0]     low_value,
	input  wire logic [pswc_pkg::FLD_W-1:0]     high_value,
	input  wire pswc_pkg::val_t                 head,
	output pswc_pkg::ring_ctl_t                 ring,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [pswc_pkg::FLD_W-1:0]          match_count
);

	localparam int IDX_W = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	localparam int CW    = ((IDX_W > pswc_pkg::FLD_W) ? IDX_W : pswc_pkg::FLD_W) + 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int SW    = (CNT_W > pswc_pkg::FLD_W) ? CNT_W : pswc_pkg::FLD_W;

	typedef enum logic [1:0] {
		IDLE,
		LAP_READ,
		LAP_MAIN,
		FIN
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]           ptr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [1:0]                 op_q;
	logic [pswc_pkg::FLD_W-1:0] a_q;
	logic [pswc_pkg::FLD_W-1:0] b_q;
	logic [pswc_pkg::FLD_W-1:0] lo_q;
	logic [pswc_pkg::FLD_W-1:0] hi_q;
	pswc_pkg::val_t             val_q;
	pswc_pkg::val_t             va_q;
	pswc_pkg::val_t             vb_q;

	logic [CW-1:0]              ptr_x;
	logic [CW-1:0]              a_x;
	logic [CW-1:0]              b_x;
	logic [pswc_pkg::FLD_W-1:0] head_x;
	logic                       hit_a;
	logic                       hit_b;
	logic                       swap_ok;
	logic                       last;
	logic                       match;
	logic                       accept;
	logic [SW-1:0]              cnt_x;
	logic [pswc_pkg::FLD_W-1:0] cnt_sat;

	assign item_stall = (state_q != IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		ptr_x   = CW'(ptr_q);
		a_x     = CW'(a_q);
		b_x     = CW'(b_q);
		head_x  = pswc_pkg::FLD_W'(head);
		hit_a   = (ptr_x == a_x);
		hit_b   = (ptr_x == b_x);
		swap_ok = (a_x < CW'(ENTRIES)) && (b_x < CW'(ENTRIES));
		last    = (ptr_q == IDX_W'(ENTRIES - 1));
		// position window and value window; the end clamps itself
		match   = (ptr_x >= a_x) && (ptr_x < b_x) && (lo_q <= head_x) && (head_x < hi_q);
		cnt_x   = SW'(cnt_q);
		cnt_sat = (cnt_x > SW'(pswc_pkg::COUNT_MAX)) ? pswc_pkg::COUNT_MAX
			: cnt_x[pswc_pkg::FLD_W-1:0];
	end

	always_comb begin
		ring.shift = (state_q == LAP_READ) || (state_q == LAP_MAIN);
		ring.fb    = head;
		if (state_q == LAP_MAIN) begin
			case (op_q)
				pswc_pkg::OP_LOAD: begin
					if (hit_a) begin
						ring.fb = val_q;
					end
				end
				pswc_pkg::OP_SWAP: begin
					if (swap_ok && hit_a) begin
						ring.fb = vb_q;
					end else if (swap_ok && hit_b) begin
						ring.fb = va_q;
					end
				end
				default: begin
					ring.fb = head;
				end
			endcase
		end
	end

	// item fields and swap operands
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			a_q   <= first_index;
			b_q   <= second_index;
			lo_q  <= low_value;
			hi_q  <= high_value;
			val_q <= load_value;
		end
		if (state_q == LAP_READ) begin
			if (hit_a) begin
				va_q <= head;
			end
			if (hit_b) begin
				vb_q <= head;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			ptr_q        <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
			match_count  <= '0;
		end else begin
			// FIN owns result_valid while it is active
			if (result_valid && !result_stall && state_q != FIN) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						cnt_q <= '0;
						case (operation) inside
							pswc_pkg::OP_SWAP:                    state_q <= LAP_READ;
							pswc_pkg::OP_LOAD, pswc_pkg::OP_COUNT: state_q <= LAP_MAIN;
							default:                              state_q <= IDLE;
						endcase
					end
				end
				LAP_READ: begin
					if (last) begin
						ptr_q   <= '0;
						state_q <= LAP_MAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				LAP_MAIN: begin
					if (op_q == pswc_pkg::OP_COUNT && match) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (last) begin
						ptr_q   <= '0;
						state_q <= (op_q == pswc_pkg::OP_COUNT) ? FIN : IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				FIN: begin
					// wait for the output register to be free
					if (!result_valid || !result_stall) begin
						result_valid <= 1'b1;
						match_count  <= cnt_sat;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/permutation_swap_range_count.sv
// top level: ring of entry cells with a lap sequencer
//
//  channel  | valid        | stall        | payload
//  item     | item_valid   | item_stall   | operation, first_index, second_index,
//           |              |              | load_value, low_value, high_value
//  result   | result_valid | result_stall | match_count
//
// the entries rotate one cell per cycle past the head cell while a lap runs; load and count take one lap
// swap takes two laps (read lap, write lap); a count then goes through FIN to post its result
// an unknown operation is taken and dropped without leaving IDLE
// item_stall is high whenever the sequencer is not idle; a finished count waits while the result
// beat is stalled, and the next item is taken while that beat is still pending
// reset clears control only; entries hold garbage until loaded
`default_nettype none

module permutation_swap_range_count #(
	parameter int ENTRIES = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic [1:0]                 operation,
	input  wire logic [pswc_pkg::FLD_W-1:0] first_index,
	input  wire logic [pswc_pkg::FLD_W-1:0] second_index,
	input  wire logic [pswc_pkg::VAL_W-1:0] load_value,
	input  wire logic [pswc_pkg::FLD_W-1:0] low_value,
	input  wire logic [pswc_pkg::FLD_W-1:0] high_value,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [pswc_pkg::FLD_W-1:0]      match_count
);

	pswc_pkg::val_t      cell_q [ENTRIES];
	pswc_pkg::ring_ctl_t ring;

	pswc_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.first_index  (first_index),
		.second_index (second_index),
		.load_value   (load_value),
		.low_value    (low_value),
		.high_value   (high_value),
		.head         (cell_q[0]),
		.ring         (ring),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.match_count  (match_count)
	);

	// cell i takes from cell i+1; the last cell takes the head after update
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_tail
			pswc_cell u_cell (
				.clk   (clk),
				.shift (ring.shift),
				.nxt   (ring.fb),
				.value (cell_q[i])
			);
		end else begin : g_body
			pswc_cell u_cell (
				.clk   (clk),
				.shift (ring.shift),
				.nxt   (cell_q[i+1]),
				.value (cell_q[i])
			);
		end
	end

endmodule

`default_nettype wire

>>> test/tb_permutation_swap_range_count.sv
// testbench for permutation_swap_range_count: directed and random beats checked against a table shadow
module tb_permutation_swap_range_count;

	localparam int TABLE_SIZE = 1024;
	localparam int FIELD_TOP = 1024;
	localparam int RANDOM_CMDS = 400;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef logic [pswc_pkg::FLD_W-1:0] fld_t;

	typedef struct {
		logic [1:0]     op;
		fld_t           pos_a;
		fld_t           pos_b;
		pswc_pkg::val_t value;
		fld_t           lo;
		fld_t           hi;
		bit             wait_idle;
	} pswc_cmd_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	logic [1:0]     operation = pswc_pkg::OP_LOAD;
	fld_t           first_index = '0;
	fld_t           second_index = '0;
	pswc_pkg::val_t load_value = '0;
	fld_t           low_value = '0;
	fld_t           high_value = '0;
	logic           result_valid;
	logic           result_stall = 1'b0;
	fld_t           match_count;

	pswc_cmd_t      cmd_queue[$];
	fld_t           expected_counts[$];
	pswc_pkg::val_t shadow[TABLE_SIZE];
	int             perm[FIELD_TOP];
	pswc_cmd_t      head;
	fld_t           want;

	// positions [0, lo_fill) and [hi_fill, TABLE_SIZE) are known to be written
	int lo_fill = 0;
	int hi_fill = TABLE_SIZE;
	int live_cmds = 0;
	int error_count = 0;
	int items_offered = 0;
	int items_taken = 0;
	int gap_left = 0;
	int calm_left = 0;
	int stall_left = 0;
	int quiet_left = 0;

	permutation_swap_range_count #(
		.ENTRIES(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.first_index(first_index),
		.second_index(second_index),
		.load_value(load_value),
		.low_value(low_value),
		.high_value(high_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.match_count(match_count)
	);

	always #10 clk = ~clk;

	task automatic flag_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic fld_t count_span(int unsigned s, int unsigned e,
			int unsigned lo, int unsigned hi);
		int unsigned n;
		n = 0;
		if (e > TABLE_SIZE)
			e = TABLE_SIZE;
		if (s < e && lo < hi) begin
			for (int unsigned p = s; p < e; p++)
				if (shadow[p] >= lo && shadow[p] < hi)
					n++;
		end
		return (n > pswc_pkg::COUNT_MAX) ? pswc_pkg::COUNT_MAX : fld_t'(n);
	endfunction

	task automatic absorb_cmd();
		pswc_pkg::val_t held;
		case (operation)
			pswc_pkg::OP_LOAD: begin
				if (first_index < TABLE_SIZE)
					shadow[first_index] = load_value;
			end
			pswc_pkg::OP_SWAP: begin
				if (first_index < TABLE_SIZE && second_index < TABLE_SIZE) begin
					held = shadow[first_index];
					shadow[first_index] = shadow[second_index];
					shadow[second_index] = held;
				end
			end
			pswc_pkg::OP_COUNT: begin
				expected_counts.push_back(count_span(first_index, second_index,
					low_value, high_value));
			end
			default: ;
		endcase
	endtask

	task automatic add_cmd(logic [1:0] op, int a, int b, int v, int lo, int hi);
		pswc_cmd_t c;
		c.op = op;
		c.pos_a = fld_t'(a);
		c.pos_b = fld_t'(b);
		c.value = pswc_pkg::val_t'(v);
		c.lo = fld_t'(lo);
		c.hi = fld_t'(hi);
		c.wait_idle = ($urandom_range(0, 59) == 0);
		cmd_queue.push_back(c);
		if (op == pswc_pkg::OP_LOAD && a < TABLE_SIZE) begin
			if (a == lo_fill)
				lo_fill++;
			else if (a == hi_fill - 1)
				hi_fill--;
			if (lo_fill >= hi_fill) begin
				lo_fill = TABLE_SIZE;
				hi_fill = TABLE_SIZE;
			end
		end
		if (!(op == OP_NONE || (op == pswc_pkg::OP_LOAD && a >= TABLE_SIZE) ||
				(op == pswc_pkg::OP_SWAP && (a >= TABLE_SIZE || b >= TABLE_SIZE))))
			live_cmds++;
	endtask

	function automatic int pick_written();
		if (hi_fill >= TABLE_SIZE || (lo_fill > 0 && $urandom_range(0, 1) == 1))
			return $urandom_range(0, lo_fill - 1);
		return $urandom_range(hi_fill, TABLE_SIZE - 1);
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 40);
		return $urandom_range(200, 1200);
	endfunction

	// item driver: one beat at a time from cmd_queue
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_valid && items_taken == items_offered)
				item_valid = 1'b0;
			if (!item_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].wait_idle && expected_counts.size() != 0)) begin
					head = cmd_queue.pop_front();
					operation = head.op;
					first_index = head.pos_a;
					second_index = head.pos_b;
					load_value = head.value;
					low_value = head.lo;
					high_value = head.hi;
					item_valid = 1'b1;
					items_offered++;
					if (calm_left != 0) begin
						calm_left--;
						gap_left = 0;
					end else begin
						gap_left = pick_idle();
						if ($urandom_range(0, 39) == 0)
							calm_left = 20;
					end
				end
			end
		end
	end

	// result backpressure with occasional quiet stretches
	always @(negedge clk) begin
		if (quiet_left != 0) begin
			quiet_left--;
			result_stall = 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			result_stall = 1'b1;
		end else begin
			result_stall = 1'b0;
			if ($urandom_range(0, 2999) == 0)
				quiet_left = $urandom_range(500, 3000);
			else if ($urandom_range(0, 7) == 0)
				stall_left = pick_idle();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				items_taken++;
				absorb_cmd();
			end
			if (result_valid && !result_stall) begin
				if (expected_counts.size() == 0) begin
					flag_error($sformatf("match_count %0d with no count pending", match_count));
				end else begin
					want = expected_counts.pop_front();
					if (match_count !== want)
						flag_error($sformatf("match_count %0d, want %0d", match_count, want));
				end
			end
		end
	end

	initial begin
		int r, a, b, s, e, lo, hi, t, base;
		for (int i = 0; i < TABLE_SIZE; i++)
			shadow[i] = '0;
		for (int i = 0; i < FIELD_TOP; i++)
			perm[i] = i;
		for (int i = FIELD_TOP - 1; i > 0; i--) begin
			r = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[r];
			perm[r] = t;
		end

		// directed: value extremes at both table ends, swaps, ignored beats, empty and clamped ranges
		add_cmd(pswc_pkg::OP_LOAD, 0, 0, 1023, 0, 0);
		add_cmd(pswc_pkg::OP_LOAD, TABLE_SIZE - 1, 0, 0, 0, 0);
		add_cmd(pswc_pkg::OP_LOAD, 1, 0, 0, 0, 0);
		add_cmd(pswc_pkg::OP_LOAD, TABLE_SIZE - 2, 0, 1023, 0, 0);
		add_cmd(pswc_pkg::OP_LOAD, FIELD_TOP, FIELD_TOP, 555, FIELD_TOP, FIELD_TOP);
		add_cmd(pswc_pkg::OP_LOAD, TABLE_SIZE, 0, 1, 0, 0);
		add_cmd(pswc_pkg::OP_COUNT, 0, 2, 0, 0, FIELD_TOP);
		add_cmd(pswc_pkg::OP_COUNT, TABLE_SIZE - 2, FIELD_TOP, 0, 0, 1);
		add_cmd(pswc_pkg::OP_COUNT, 0, 2, 0, 1023, FIELD_TOP);
		add_cmd(pswc_pkg::OP_COUNT, 2, 1, 0, 0, FIELD_TOP);
		add_cmd(pswc_pkg::OP_COUNT, FIELD_TOP, FIELD_TOP, 0, 0, FIELD_TOP);
		add_cmd(pswc_pkg::OP_COUNT, 0, 2, 0, 5, 5);
		add_cmd(pswc_pkg::OP_COUNT, 0, 2, 0, FIELD_TOP, 0);
		add_cmd(pswc_pkg::OP_SWAP, 0, TABLE_SIZE - 1, 0, 0, 0);
		add_cmd(pswc_pkg::OP_SWAP, TABLE_SIZE - 1, 0, 0, 0, 0);
		add_cmd(pswc_pkg::OP_SWAP, 1, 1, 0, 0, 0);
		add_cmd(pswc_pkg::OP_SWAP, 0, FIELD_TOP, 0, 0, 0);
		add_cmd(pswc_pkg::OP_SWAP, TABLE_SIZE, 1, 0, 0, 0);
		add_cmd(pswc_pkg::OP_COUNT, 0, 2, 0, 0, 1);
		add_cmd(OP_NONE, 3, 7, 9, 11, 13);
		add_cmd(pswc_pkg::OP_COUNT, TABLE_SIZE - 2, TABLE_SIZE, 0, 0, FIELD_TOP);
		cmd_queue[$].wait_idle = 1'b1;
		add_cmd(pswc_pkg::OP_COUNT, 0, 2, 0, 0, FIELD_TOP);

		base = live_cmds;
		while (live_cmds - base < RANDOM_CMDS) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				add_cmd(OP_NONE, $urandom_range(0, FIELD_TOP), $urandom_range(0, FIELD_TOP),
					$urandom_range(0, 1023), $urandom_range(0, FIELD_TOP),
					$urandom_range(0, FIELD_TOP));
			end else if (r < 40) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					// grow one of the written regions, or rewrite a written entry once all are written, with permutation values
					if (lo_fill == TABLE_SIZE)
						a = pick_written();
					else
						a = ($urandom_range(0, 1) == 1) ? lo_fill : hi_fill - 1;
					t = perm[a];
				end else begin
					a = (r < 9) ? pick_written() : $urandom_range(0, FIELD_TOP);
					t = $urandom_range(0, 1023);
				end
				add_cmd(pswc_pkg::OP_LOAD, a, $urandom_range(0, FIELD_TOP), t,
					$urandom_range(0, FIELD_TOP), $urandom_range(0, FIELD_TOP));
			end else if (r < 62) begin
				r = $urandom_range(0, 9);
				a = pick_written();
				b = (r == 0) ? a : pick_written();
				if (r == 1)
					b = $urandom_range(TABLE_SIZE, FIELD_TOP);
				if (r == 2)
					a = $urandom_range(TABLE_SIZE, FIELD_TOP);
				add_cmd(pswc_pkg::OP_SWAP, a, b, $urandom_range(0, 1023),
					$urandom_range(0, FIELD_TOP), $urandom_range(0, FIELD_TOP));
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					s = $urandom_range(0, FIELD_TOP);
					e = $urandom_range(0, s);
				end else if (hi_fill < TABLE_SIZE &&
						(lo_fill == 0 || $urandom_range(0, 1) == 1)) begin
					s = $urandom_range(hi_fill, TABLE_SIZE);
					if ($urandom_range(0, 3) == 0)
						e = $urandom_range(TABLE_SIZE, FIELD_TOP);
					else
						e = $urandom_range(s, TABLE_SIZE);
				end else begin
					s = $urandom_range(0, lo_fill);
					e = $urandom_range(s, lo_fill);
					if (lo_fill == TABLE_SIZE && $urandom_range(0, 3) == 0)
						e = $urandom_range(TABLE_SIZE, FIELD_TOP);
				end
				r = $urandom_range(0, 9);
				lo = (r < 2) ? 0 : $urandom_range(0, FIELD_TOP);
				hi = (r == 9) ? $urandom_range(0, lo) : $urandom_range(lo, FIELD_TOP);
				add_cmd(pswc_pkg::OP_COUNT, s, e, $urandom_range(0, 1023), lo, hi);
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (cmd_queue.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_counts.size() != 0)
			@(posedge clk);
		// a swap still in its write lap gives no beat, so let it finish
		repeat (2 * TABLE_SIZE + 20) @(posedge clk);
		if (error_count == 0)
			$display("tb_permutation_swap_range_count: clean");
		else
			$display("tb_permutation_swap_range_count: errors");
		$finish;
	end

	initial begin
		#200000000;
		$display("tb_permutation_swap_range_count: errors");
		$finish;
	end

endmodule

>>> filelist.f
src/pswc_pkg.sv
src/pswc_cell.sv
src/pswc_ctrl.sv
src/permutation_swap_range_count.sv
test/tb_permutation_swap_range_count.sv
